[design/ffa_pkg.sv]
// Shared types, constants and codes of the first-fit heap allocator.
package ffa_pkg;

  // Default sizing of the heap
  localparam int MAX_BLOCKS_DEF = 8;
  localparam int MAX_FREE_DEF   = 32;

  // Field widths
  localparam int SZ_W  = 33;
  localparam int OFF_W = 32;

  // Configuration reset values and the alignment used when both are zero
  localparam logic [SZ_W-1:0] BLOCK_SIZE_RST = 33'd67108864;
  localparam logic [SZ_W-1:0] DEF_ALIGN_RST  = 33'd256;
  localparam logic [SZ_W-1:0] FALLBACK_ALIGN = 33'd256;

  // Configuration register indexes (selected by paddr bit 3)
  localparam logic REG_BLOCK_SIZE = 1'b0;
  localparam logic REG_DEF_ALIGN  = 1'b1;

  // Commands
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes
  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_ZERO     = 3'd1;
  localparam logic [2:0] STAT_NOBLOCK  = 3'd2;
  localparam logic [2:0] STAT_TOOLARGE = 3'd3;
  localparam logic [2:0] STAT_FULL     = 3'd4;
  localparam logic [2:0] STAT_BADINDEX = 3'd5;

  // Remainder unit: one quotient bit per cycle
  localparam int DIV_STEPS = SZ_W;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  typedef struct packed {
    logic            start;
    logic [SZ_W-1:0] dividend;
    logic [SZ_W-1:0] divisor;
  } ffa_div_req_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_LOOK,
    S_DIV,
    S_FIT,
    S_DROP,
    S_DROPW,
    S_UP,
    S_UPW,
    S_TAIL,
    S_DONE
  } ffa_state_e;

endpackage

[design/ffa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ffa_ram #(
  parameter int WIDTH = 66,
  parameter int DEPTH = 256
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/ffa_rem_div.sv]
// Restoring remainder unit: one dividend bit per cycle.
module ffa_rem_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ffa_pkg::ffa_div_req_t     req_i,
  output logic                      done_o,
  output logic [ffa_pkg::SZ_W-1:0]  rem_o
);
  import ffa_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DIV_CW-1:0] step_q, step_d;
  logic [SZ_W-1:0]   rem_q, rem_d;
  logic [SZ_W-1:0]   dvd_q, dvd_d;
  logic [SZ_W-1:0]   dvs_q, dvs_d;
  logic [SZ_W:0]     trial;

  // Shift in the next dividend bit and subtract when it fits
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    trial  = {rem_q, dvd_q[SZ_W-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = SZ_W'(trial - {1'b0, dvs_q});
      end else begin
        rem_d = trial[SZ_W-1:0];
      end
      dvd_d  = {dvd_q[SZ_W-2:0], 1'b0};
      step_d = step_q + 1'b1;
      if (step_q == DIV_CW'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

[design/first_fit_aligned_heap_allocator.sv]
// A free reads and compares list entries one at a time and moves the entries behind a merged one down.
// An allocate tries the free entries one at a time, waiting on the remainder unit for each,
// and moves entries when it drops or splits one.
// Throughput: one transfer at a time; the next is taken once the result is registered.
// Reset clears block count, list counts and the result valid flag and restores the configuration
// to its reset values at once; list entries in the RAM need no clearing pass.
module first_fit_aligned_heap_allocator #(
  parameter int MAX_BLOCKS = ffa_pkg::MAX_BLOCKS_DEF,
  parameter int MAX_FREE   = ffa_pkg::MAX_FREE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [32:0] request_size_i,
  input  logic [32:0] alignment_i,
  input  logic [2:0]  block_index_i,
  input  logic [31:0] region_offset_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [2:0]  result_block_o,
  output logic [31:0] result_offset_o,
  output logic [32:0] result_size_o
);
  import ffa_pkg::*;

  localparam int OCW   = $clog2(MAX_BLOCKS + 1);
  localparam int BW    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW    = $clog2(MAX_FREE + 1);
  localparam int FW    = $clog2(MAX_FREE);
  localparam int DEPTH = MAX_BLOCKS * MAX_FREE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EW    = 2 * SZ_W;

  function automatic logic [AW-1:0] ent_addr(input logic [OCW-1:0] b, input logic [CW-1:0] k);
    return AW'(b[BW-1:0]) * AW'(MAX_FREE) + AW'(k[FW-1:0]);
  endfunction

  // Control state
  ffa_state_e       state_q, state_d;
  logic [OCW-1:0]   blocks_open_q, blocks_open_d;
  logic [CW-1:0]    cnt_q [MAX_BLOCKS];
  logic [SZ_W-1:0]  block_size_q, def_align_q;
  logic             out_valid_q, out_valid_d;

  // Item payload
  logic             cmd_q, cmd_d;
  logic [SZ_W-1:0]  size_q, size_d, align_q, align_d;
  logic [OCW-1:0]   blk_q, blk_d;
  logic [CW-1:0]    idx_q, idx_d, k_q, k_d;
  logic             pass2_q, pass2_d;
  logic [SZ_W-1:0]  st_q, st_d, len_q, len_d, ns_q, ns_d, nl_q, nl_d;
  logic [2:0]       res_status_q, res_status_d, res_block_q, res_block_d;
  logic [31:0]      res_offset_q, res_offset_d;
  logic [SZ_W-1:0]  res_size_q, res_size_d;
  logic [2:0]       out_status_q, out_block_q;
  logic [31:0]      out_offset_q;
  logic [SZ_W-1:0]  out_size_q;

  // Memory, count and divider controls
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [EW-1:0]    ram_wdata, ram_rdata;
  logic             cnt_we;
  logic [CW-1:0]    cnt_wval;
  ffa_div_req_t     div_req;
  logic             div_done;
  logic [SZ_W-1:0]  div_rem;

  // Decisions
  logic [CW-1:0]    cnt_cur;
  logic             blk_live, idx_end, out_free, in_take, early;
  logic [SZ_W-1:0]  rd_st, rd_len, sum_len, pad_gap, pad_len, tail_len;
  logic [SZ_W:0]    end_rd, end_new, at_w, fend_w;
  logic [SZ_W+1:0]  aend_w, tail_w;
  logic             c_low, c_high, fit_miss, fit_front, fit_back;

  ffa_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ffa_rem_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .rem_o  (div_rem)
  );

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[3] == REG_DEF_ALIGN) ? {31'd0, def_align_q} : {31'd0, block_size_q};

  // Shared conditions
  assign cnt_cur  = cnt_q[blk_q[BW-1:0]];
  assign blk_live = blk_q < blocks_open_q;
  assign idx_end  = idx_q >= cnt_cur;
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_take  = in_valid_i && (state_q == S_IDLE);
  assign early    = (command_i == CMD_ALLOC) ? (request_size_i == '0)
                  : ((32'(block_index_i) >= 32'(blocks_open_q)) || (request_size_i == '0));

  // Free: neighbor test against the entry just read
  assign rd_st   = ram_rdata[EW-1:SZ_W];
  assign rd_len  = ram_rdata[SZ_W-1:0];
  assign end_rd  = {1'b0, rd_st} + {1'b0, rd_len};
  assign end_new = {1'b0, ns_q} + {1'b0, nl_q};
  assign c_low   = end_rd == {1'b0, ns_q};
  assign c_high  = end_new == {1'b0, rd_st};
  assign sum_len = rd_len + nl_q;

  // Allocate: aligned placement inside the latched entry
  assign pad_gap   = align_q - div_rem;
  assign at_w      = {1'b0, st_q} + ((div_rem != '0) ? {1'b0, pad_gap} : '0);
  assign fend_w    = {1'b0, st_q} + {1'b0, len_q};
  assign aend_w    = {1'b0, at_w} + {2'b00, size_q};
  assign fit_miss  = aend_w > {1'b0, fend_w};
  assign fit_front = at_w == {1'b0, st_q};
  assign fit_back  = aend_w == {1'b0, fend_w};
  assign tail_w    = {1'b0, fend_w} - aend_w;
  assign tail_len  = tail_w[SZ_W-1:0];
  assign pad_len   = at_w[SZ_W-1:0] - st_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_take) begin
          state_d = early ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (cmd_q == CMD_ALLOC) begin
          if (!blk_live) begin
            state_d = S_DONE;
          end else if (!idx_end) begin
            state_d = S_LOOK;
          end
        end else begin
          state_d = idx_end ? S_DONE : S_LOOK;
        end
      end
      S_LOOK: begin
        if (cmd_q == CMD_ALLOC) begin
          state_d = S_DIV;
        end else if (c_low || c_high) begin
          state_d = pass2_q ? S_DONE : S_DROP;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_FIT;
        end
      end
      S_FIT: begin
        priority if (fit_miss) begin
          state_d = S_SCAN;
        end else if (fit_front && fit_back) begin
          state_d = S_DROP;
        end else if (fit_front || fit_back) begin
          state_d = S_DONE;
        end else if (cnt_cur >= CW'(MAX_FREE)) begin
          state_d = S_DONE;
        end else begin
          state_d = S_UP;
        end
      end
      S_DROP: begin
        if (k_q < cnt_cur) begin
          state_d = S_DROPW;
        end else begin
          state_d = (cmd_q == CMD_ALLOC) ? S_DONE : S_SCAN;
        end
      end
      S_DROPW: state_d = S_DROP;
      S_UP:    state_d = (k_q > idx_q) ? S_UPW : S_TAIL;
      S_UPW:   state_d = S_UP;
      S_TAIL:  state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    cmd_d         = cmd_q;
    size_d        = size_q;
    align_d       = align_q;
    blk_d         = blk_q;
    idx_d         = idx_q;
    k_d           = k_q;
    pass2_d       = pass2_q;
    st_d          = st_q;
    len_d         = len_q;
    ns_d          = ns_q;
    nl_d          = nl_q;
    res_status_d  = res_status_q;
    res_block_d   = res_block_q;
    res_offset_d  = res_offset_q;
    res_size_d    = res_size_q;
    blocks_open_d = blocks_open_q;
    out_valid_d   = out_valid_q && out_stall_i;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = '0;
    cnt_we        = 1'b0;
    cnt_wval      = '0;
    div_req       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_take) begin
          cmd_d        = command_i;
          size_d       = request_size_i;
          if (alignment_i != '0) begin
            align_d = alignment_i;
          end else begin
            align_d = (def_align_q != '0) ? def_align_q : FALLBACK_ALIGN;
          end
          blk_d        = (command_i == CMD_FREE) ? OCW'(block_index_i) : '0;
          idx_d        = '0;
          pass2_d      = 1'b0;
          ns_d         = SZ_W'(region_offset_i);
          nl_d         = request_size_i;
          res_status_d = STAT_OK;
          res_block_d  = '0;
          res_offset_d = '0;
          res_size_d   = '0;
          if (command_i == CMD_FREE && 32'(block_index_i) >= 32'(blocks_open_q)) begin
            res_status_d = STAT_BADINDEX;
          end else if (request_size_i == '0) begin
            res_status_d = STAT_ZERO;
          end
        end
      end
      S_SCAN: begin
        if (cmd_q == CMD_ALLOC) begin
          if (!blk_live) begin
            // Nothing fits: open the next block, if one is left and the request fits in a block
            priority if (blocks_open_q >= OCW'(MAX_BLOCKS)) begin
              res_status_d = STAT_NOBLOCK;
            end else if (size_q > block_size_q) begin
              res_status_d = STAT_TOOLARGE;
            end else begin
              blocks_open_d = blocks_open_q + 1'b1;
              cnt_we        = 1'b1;
              cnt_wval      = (size_q == block_size_q) ? '0 : CW'(1);
              ram_we        = size_q != block_size_q;
              ram_waddr     = ent_addr(blk_q, '0);
              ram_wdata     = {size_q, block_size_q - size_q};
              res_status_d  = STAT_OK;
              res_block_d   = 3'(blk_q);
              res_offset_d  = '0;
              res_size_d    = size_q;
            end
          end else if (idx_end) begin
            blk_d = blk_q + 1'b1;
            idx_d = '0;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = ent_addr(blk_q, idx_q);
          end
        end else if (idx_end) begin
          // Append, or report a full list
          if (cnt_cur >= CW'(MAX_FREE)) begin
            res_status_d = STAT_FULL;
          end else begin
            ram_we       = 1'b1;
            ram_waddr    = ent_addr(blk_q, cnt_cur);
            ram_wdata    = {ns_q, nl_q};
            cnt_we       = 1'b1;
            cnt_wval     = cnt_cur + 1'b1;
            res_status_d = STAT_OK;
          end
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ent_addr(blk_q, idx_q);
        end
      end
      S_LOOK: begin
        st_d  = rd_st;
        len_d = rd_len;
        if (cmd_q == CMD_ALLOC) begin
          div_req.start    = 1'b1;
          div_req.dividend = rd_st;
          div_req.divisor  = align_q;
        end else if (c_low || c_high) begin
          if (pass2_q) begin
            // Second merge: widen the neighbor in place
            ram_we       = 1'b1;
            ram_waddr    = ent_addr(blk_q, idx_q);
            ram_wdata    = {(c_low ? rd_st : ns_q), sum_len};
            res_status_d = STAT_OK;
          end else begin
            // First merge: absorb the neighbor and drop it from the list
            nl_d     = sum_len;
            ns_d     = c_low ? rd_st : ns_q;
            k_d      = idx_q;
            cnt_we   = 1'b1;
            cnt_wval = cnt_cur - 1'b1;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_DIV: begin
      end
      S_FIT: begin
        if (fit_miss) begin
          idx_d = idx_q + 1'b1;
        end else begin
          res_status_d = STAT_OK;
          res_block_d  = 3'(blk_q);
          res_offset_d = at_w[31:0];
          res_size_d   = size_q;
          priority if (fit_front && fit_back) begin
            k_d      = idx_q;
            cnt_we   = 1'b1;
            cnt_wval = cnt_cur - 1'b1;
          end else if (fit_front) begin
            ram_we    = 1'b1;
            ram_waddr = ent_addr(blk_q, idx_q);
            ram_wdata = {aend_w[SZ_W-1:0], tail_len};
          end else if (fit_back) begin
            ram_we    = 1'b1;
            ram_waddr = ent_addr(blk_q, idx_q);
            ram_wdata = {st_q, pad_len};
          end else if (cnt_cur >= CW'(MAX_FREE)) begin
            res_status_d = STAT_FULL;
            res_block_d  = '0;
            res_offset_d = '0;
            res_size_d   = '0;
          end else begin
            k_d      = cnt_cur;
            cnt_we   = 1'b1;
            cnt_wval = cnt_cur + 1'b1;
          end
        end
      end
      S_DROP: begin
        // Move the entries behind the dropped one down by one place
        if (k_q < cnt_cur) begin
          ram_re    = 1'b1;
          ram_raddr = ent_addr(blk_q, k_q + 1'b1);
        end else if (cmd_q == CMD_FREE) begin
          pass2_d = 1'b1;
          idx_d   = '0;
        end
      end
      S_DROPW: begin
        ram_we    = 1'b1;
        ram_waddr = ent_addr(blk_q, k_q);
        ram_wdata = ram_rdata;
        k_d       = k_q + 1'b1;
      end
      S_UP: begin
        // Open a gap after the split entry, then write the padding part
        if (k_q > idx_q) begin
          ram_re    = 1'b1;
          ram_raddr = ent_addr(blk_q, k_q - 1'b1);
        end else begin
          ram_we    = 1'b1;
          ram_waddr = ent_addr(blk_q, idx_q);
          ram_wdata = {st_q, pad_len};
        end
      end
      S_UPW: begin
        ram_we    = 1'b1;
        ram_waddr = ent_addr(blk_q, k_q);
        ram_wdata = ram_rdata;
        k_d       = k_q - 1'b1;
      end
      S_TAIL: begin
        ram_we    = 1'b1;
        ram_waddr = ent_addr(blk_q, idx_q + 1'b1);
        ram_wdata = {aend_w[SZ_W-1:0], tail_len};
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      blocks_open_q <= '0;
      out_valid_q   <= 1'b0;
      block_size_q  <= BLOCK_SIZE_RST;
      def_align_q   <= DEF_ALIGN_RST;
      for (int b = 0; b < MAX_BLOCKS; b++) begin
        cnt_q[b] <= '0;
      end
    end else begin
      state_q       <= state_d;
      blocks_open_q <= blocks_open_d;
      out_valid_q   <= out_valid_d;
      if (cnt_we) begin
        cnt_q[blk_q[BW-1:0]] <= cnt_wval;
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[3] == REG_BLOCK_SIZE) begin
          block_size_q <= pwdata[SZ_W-1:0];
        end else begin
          def_align_q <= pwdata[SZ_W-1:0];
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    size_q       <= size_d;
    align_q      <= align_d;
    blk_q        <= blk_d;
    idx_q        <= idx_d;
    k_q          <= k_d;
    pass2_q      <= pass2_d;
    st_q         <= st_d;
    len_q        <= len_d;
    ns_q         <= ns_d;
    nl_q         <= nl_d;
    res_status_q <= res_status_d;
    res_block_q  <= res_block_d;
    res_offset_q <= res_offset_d;
    res_size_q   <= res_size_d;
    if (state_q == S_DONE && out_free) begin
      out_status_q <= res_status_q;
      out_block_q  <= res_block_q;
      out_offset_q <= res_offset_q;
      out_size_q   <= res_size_q;
    end
  end

  assign in_stall_o      = state_q != S_IDLE;
  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign result_block_o  = out_block_q;
  assign result_offset_o = out_offset_q;
  assign result_size_o   = out_size_q;

`ifndef ASSERT_OFF
  a_open_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(blocks_open_q) <= MAX_BLOCKS)
    else $error("more blocks open than exist");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is in work");

  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STAT_OK |-> result_size_o == '0 && result_offset_o == '0)
    else $error("failed result carries a grant");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= STAT_BADINDEX)
    else $error("status code out of range");

  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LOOK && cmd_q == CMD_ALLOC |=> state_q == S_DIV && !div_done)
    else $error("remainder used before it is ready");
`endif

endmodule
